FILE: rtl/itf_pkg.sv
package itf_pkg;

  localparam int VALUE_BITS = 32;
  localparam int MAX_FIELD  = 60;
  localparam int FIELD_W    = 6;

  localparam int NDIG       = (VALUE_BITS + 2) / 3;
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int DIG_W      = 4 * NDIG;
  localparam int ND_W       = $clog2(NDIG + 1);
  localparam int BIT_CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int CNT_W      = 7;

  localparam logic [1:0] RADIX_OCT  = 2'd0;
  localparam logic [1:0] RADIX_DEC  = 2'd1;
  localparam logic [1:0] RADIX_HEX  = 2'd2;
  localparam logic [1:0] RADIX_RSVD = 2'd3;

  localparam logic [1:0] SIGN_NONE  = 2'd0;
  localparam logic [1:0] SIGN_BLANK = 2'd1;
  localparam logic [1:0] SIGN_FORCE = 2'd2;
  localparam logic [1:0] SIGN_RSVD  = 2'd3;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_A     = 8'h61;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  is_signed;
    logic [1:0]            radix_code;
    logic [1:0]            sign_mode;
    logic                  alternate_form;
    logic                  left_align;
    logic                  zero_pad;
    logic                  has_width;
    logic [FIELD_W-1:0]    field_width;
    logic                  has_precision;
    logic [FIELD_W-1:0]    digit_precision;
  } req_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } res_t;

  typedef struct packed {
    logic            done;
    logic [ND_W-1:0] nd;
  } dstat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {4'd0, d};
    end else begin
      digit_char = CH_A + {4'd0, d - 4'd10};
    end
  endfunction

endpackage

FILE: rtl/int_to_text_formatter_core.sv
// Decimal values first pass a bit-serial binary to BCD conversion, octal and hex do not;
// then leading zero digits are stripped, 0 to 10 of them, before the field is planned.
// Characters follow one per cycle, up to 63, on strobe; the receiver cannot stall.
// Busy holds from acceptance through the whole conversion, so no new request is taken
// until it ends; busy drops in the cycle of the last beat.
// Synchronous active-high reset returns to idle with no strobe.
module int_to_text_formatter_core import itf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic strobe,
  output res_t res
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WAIT = 2'd1;
  localparam logic [1:0] S_PLAN = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]            st;
  req_t                  rq;
  logic                  neg;
  logic                  mag_zero;
  logic                  accept;
  logic                  neg_in;
  logic [VALUE_BITS-1:0] mag_in;
  dstat_t                dstat;
  logic [3:0]            top_digit;
  logic                  next_digit;

  logic [CNT_W-1:0] wsat, psat, ndx, w1a, tot, dw;
  logic [CNT_W-1:0] p_w0, p_w1, p_w2, p_tot;
  logic             nodig, sw, p0, px;

  logic [CNT_W-1:0] c_w0, c_w1, c_nd, c_w2, remain;
  logic             f_sw, f_p0, f_px;
  logic [7:0]       ch;

  assign accept = start && !busy;
  assign busy   = (st != S_IDLE);
  assign neg_in = req.is_signed && req.value[VALUE_BITS-1];
  assign mag_in = neg_in ? (~req.value + 1'b1) : req.value;

  itf_digits u_digits (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .mag        (mag_in),
    .radix_code (req.radix_code),
    .next_digit (next_digit),
    .dstat      (dstat),
    .top_digit  (top_digit)
  );

  always_comb begin
    wsat = '0;
    psat = '0;
    if (rq.has_width) begin
      wsat = (CNT_W'(rq.field_width) > CNT_W'(MAX_FIELD)) ? CNT_W'(MAX_FIELD)
                                                         : CNT_W'(rq.field_width);
    end
    if (rq.has_precision) begin
      psat = (CNT_W'(rq.digit_precision) > CNT_W'(MAX_FIELD)) ? CNT_W'(MAX_FIELD)
                                                             : CNT_W'(rq.digit_precision);
    end
    nodig = rq.has_precision && (rq.digit_precision == '0) && mag_zero;
    ndx   = nodig ? '0 : CNT_W'(dstat.nd);
    w1a   = (!nodig && psat > ndx) ? psat - ndx : '0;
    sw    = rq.is_signed && (neg || rq.sign_mode != SIGN_NONE);
    p0    = rq.alternate_form &&
            ((rq.radix_code == RADIX_OCT && !mag_zero) || rq.radix_code == RADIX_HEX);
    px    = rq.alternate_form && (rq.radix_code == RADIX_HEX);
    tot   = CNT_W'(sw) + CNT_W'(p0) + CNT_W'(px) + w1a + ndx;
    dw    = wsat - tot;
    p_w0  = '0;
    p_w1  = w1a;
    p_w2  = '0;
    p_tot = tot;
    if (rq.has_width && tot < wsat) begin
      p_tot = wsat;
      if (rq.left_align) begin
        p_w2 = dw;
      end else if (rq.has_precision || !rq.zero_pad) begin
        p_w0 = dw;
      end else begin
        p_w1 = w1a + dw;
      end
    end
  end

  always_comb begin
    next_digit = 1'b0;
    ch         = CH_SPACE;
    if (c_w0 != '0) begin
      ch = CH_SPACE;
    end else if (f_sw) begin
      ch = neg ? CH_MINUS : ((rq.sign_mode == SIGN_FORCE) ? CH_PLUS : CH_SPACE);
    end else if (f_p0) begin
      ch = CH_ZERO;
    end else if (f_px) begin
      ch = CH_X;
    end else if (c_w1 != '0) begin
      ch = CH_ZERO;
    end else if (c_nd != '0) begin
      ch         = digit_char(top_digit);
      next_digit = (st == S_EMIT);
    end else begin
      ch = CH_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= (st == S_EMIT);
      case (st)
        S_IDLE: begin
          if (accept) begin
            rq       <= req;
            neg      <= neg_in;
            mag_zero <= (mag_in == '0);
            st       <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (dstat.done) begin
            st <= S_PLAN;
          end
        end
        S_PLAN: begin
          c_w0   <= p_w0;
          c_w1   <= p_w1;
          c_w2   <= p_w2;
          c_nd   <= ndx;
          f_sw   <= sw;
          f_p0   <= p0;
          f_px   <= px;
          remain <= p_tot;
          st     <= (p_tot == '0) ? S_IDLE : S_EMIT;
        end
        S_EMIT: begin
          res.character <= ch;
          res.last      <= (remain == CNT_W'(1));
          remain        <= remain - 1'b1;
          if (c_w0 != '0) begin
            c_w0 <= c_w0 - 1'b1;
          end else if (f_sw) begin
            f_sw <= 1'b0;
          end else if (f_p0) begin
            f_p0 <= 1'b0;
          end else if (f_px) begin
            f_px <= 1'b0;
          end else if (c_w1 != '0) begin
            c_w1 <= c_w1 - 1'b1;
          end else if (c_nd != '0) begin
            c_nd <= c_nd - 1'b1;
          end else begin
            c_w2 <= c_w2 - 1'b1;
          end
          if (remain == CNT_W'(1)) begin
            st <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/itf_digits.sv
module itf_digits import itf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic [VALUE_BITS-1:0] mag,
  input  logic [1:0]            radix_code,
  input  logic                  next_digit,
  output dstat_t                dstat,
  output logic [3:0]            top_digit
);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_CONV = 2'd1;
  localparam logic [1:0] D_SCAN = 2'd2;
  localparam logic [1:0] D_DONE = 2'd3;

  logic [1:0]            st;
  logic [DIG_W-1:0]      dig;
  logic [DIG_W-1:0]      adj;
  logic [DIG_W-1:0]      load_dig;
  logic [3*NDIG-1:0]     mag_o;
  logic [DIG_W-1:0]      mag_h;
  logic [VALUE_BITS-1:0] sh;
  logic [BIT_CNT_W-1:0]  bcnt;
  logic [ND_W-1:0]       nd;
  logic                  is_dec;

  assign is_dec    = (radix_code == RADIX_DEC) || (radix_code == RADIX_RSVD);
  assign mag_o     = (3*NDIG)'(mag);
  assign mag_h     = DIG_W'(mag);
  assign top_digit = dig[DIG_W-1 -: 4];
  assign dstat.done = (st == D_DONE);
  assign dstat.nd   = nd;

  always_comb begin
    for (int j = 0; j < NDIG; j++) begin
      adj[4*j +: 4] = (dig[4*j +: 4] >= 4'd5) ? dig[4*j +: 4] + 4'd3 : dig[4*j +: 4];
      if (radix_code == RADIX_OCT) begin
        load_dig[4*j +: 4] = {1'b0, mag_o[3*j +: 3]};
      end else if (j < HEX_DIGITS) begin
        load_dig[4*j +: 4] = mag_h[4*j +: 4];
      end else begin
        load_dig[4*j +: 4] = 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= D_IDLE;
    end else if (load) begin
      sh   <= mag;
      nd   <= ND_W'(NDIG);
      bcnt <= BIT_CNT_W'(VALUE_BITS);
      if (is_dec) begin
        dig <= '0;
        st  <= D_CONV;
      end else begin
        dig <= load_dig;
        st  <= D_SCAN;
      end
    end else begin
      case (st)
        D_CONV: begin
          dig  <= {adj[DIG_W-2:0], sh[VALUE_BITS-1]};
          sh   <= {sh[VALUE_BITS-2:0], 1'b0};
          bcnt <= bcnt - 1'b1;
          if (bcnt == BIT_CNT_W'(1)) begin
            st <= D_SCAN;
          end
        end
        D_SCAN: begin
          if (nd > ND_W'(1) && top_digit == 4'd0) begin
            dig <= {dig[DIG_W-5:0], 4'd0};
            nd  <= nd - 1'b1;
          end else begin
            st <= D_DONE;
          end
        end
        D_DONE: begin
          if (next_digit) begin
            dig <= {dig[DIG_W-5:0], 4'd0};
          end
        end
        default: begin
          st <= D_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/itf_checker.sv
module itf_checker import itf_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic strobe,
  input res_t res
);

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("strobe without a request in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_beats_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !res.last |=> strobe)
    else $error("gap inside a conversion");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && res.last |=> !strobe)
    else $error("beat after the last character");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy && !strobe |=> !strobe)
    else $error("strobe while idle");

endmodule

bind int_to_text_formatter_core itf_checker u_itf_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .res    (res)
);

FILE: verif/testbench.sv
module testbench import itf_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 450;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic strobe;
  res_t res;

  req_t pending_reqs[$];
  res_t expected_chars[$];
  res_t want;
  int   sent_count = 0;
  int   total_items = 1;
  int   error_count = 0;
  int   stall_cycles = 0;

  int_to_text_formatter_core uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .busy   (busy),
    .strobe (strobe),
    .res    (res)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void queue_conversion(input req_t r);
    logic [VALUE_BITS-1:0] mag;
    logic [VALUE_BITS-1:0] t;
    logic                  neg;
    int unsigned           radix;
    int                    width, prec, sw, aw, nd, w0, w1, w2, dw;
    logic [7:0]            digs[0:63];
    logic [7:0]            text[$];
    string                 digit_set;
    res_t                  c;
    digit_set = "0123456789abcdef";
    neg = r.is_signed && r.value[VALUE_BITS-1];
    mag = neg ? -r.value : r.value;
    radix = (r.radix_code == RADIX_OCT) ? 8 : (r.radix_code == RADIX_HEX) ? 16 : 10;
    width = (r.field_width > MAX_FIELD) ? MAX_FIELD : int'(r.field_width);
    prec  = (r.digit_precision > MAX_FIELD) ? MAX_FIELD : int'(r.digit_precision);
    if (!r.has_width) width = 0;
    if (!r.has_precision) prec = 0;
    sw = (r.is_signed && (neg || r.sign_mode != SIGN_NONE)) ? 1 : 0;
    aw = 0;
    if (r.alternate_form) begin
      if (radix == 8 && mag != 0) aw = 1;
      else if (radix == 16) aw = 2;
    end
    nd = 0;
    w0 = 0;
    w1 = 0;
    w2 = 0;
    if (!(r.has_precision && prec == 0 && mag == 0)) begin
      t = mag;
      do begin
        digs[nd] = digit_set[t % radix];
        nd++;
        t = t / radix;
      end while (t != 0);
      if (prec > nd) w1 = prec - nd;
    end
    if (r.has_width && sw + aw + w1 + nd < width) begin
      dw = width - (sw + aw + w1 + nd);
      if (r.left_align) w2 = dw;
      else if (r.has_precision || !r.zero_pad) w0 = dw;
      else w1 = dw;
    end
    repeat (w0) text.push_back(CH_SPACE);
    if (sw != 0) text.push_back(neg ? CH_MINUS : (r.sign_mode == SIGN_FORCE ? CH_PLUS : CH_SPACE));
    if (aw >= 1) text.push_back(CH_ZERO);
    if (aw == 2) text.push_back(CH_X);
    repeat (w1) text.push_back(CH_ZERO);
    for (int i = nd - 1; i >= 0; i--) text.push_back(digs[i]);
    repeat (w2) text.push_back(CH_SPACE);
    foreach (text[i]) begin
      c.character = text[i];
      c.last = (i == text.size() - 1);
      expected_chars.push_back(c);
    end
  endfunction

  function automatic req_t make_req(input logic [VALUE_BITS-1:0] value, input logic sgn,
                                    input logic [1:0] rc, input logic [1:0] sm,
                                    input logic alt, input logic left, input logic zpad,
                                    input logic hw, input logic [FIELD_W-1:0] fw,
                                    input logic hp, input logic [FIELD_W-1:0] dp);
    req_t r;
    r.value = value;
    r.is_signed = sgn;
    r.radix_code = rc;
    r.sign_mode = sm;
    r.alternate_form = alt;
    r.left_align = left;
    r.zero_pad = zpad;
    r.has_width = hw;
    r.field_width = fw;
    r.has_precision = hp;
    r.digit_precision = dp;
    return r;
  endfunction

  function automatic req_t random_req();
    req_t r;
    r.is_signed = 1'($urandom_range(0, 1));
    r.radix_code = 2'($urandom_range(0, 3));
    r.sign_mode = 2'($urandom_range(0, 3));
    r.alternate_form = 1'($urandom_range(0, 1));
    r.left_align = 1'($urandom_range(0, 1));
    r.zero_pad = 1'($urandom_range(0, 1));
    r.has_width = 1'($urandom_range(0, 1));
    r.field_width = ($urandom_range(0, 3) == 0) ? FIELD_W'($urandom_range(0, 63))
                                                : FIELD_W'($urandom_range(0, 16));
    r.has_precision = 1'($urandom_range(0, 1));
    r.digit_precision = ($urandom_range(0, 3) == 0) ? FIELD_W'($urandom_range(0, 63))
                                                    : FIELD_W'($urandom_range(0, 12));
    case ($urandom_range(0, 6))
      0: r.value = $urandom_range(0, 9);
      1: r.value = $urandom >> $urandom_range(0, 31);
      2: r.value = -$urandom_range(0, 300);
      3: begin
        case ($urandom_range(0, 3))
          0: r.value = '0;
          1: r.value = '1;
          2: r.value = {1'b1, {(VALUE_BITS-1){1'b0}}};
          default: r.value = {1'b0, {(VALUE_BITS-1){1'b1}}};
        endcase
      end
      4: begin
        r.value = '0;
        r.has_precision = 1'b1;
        r.digit_precision = FIELD_W'($urandom_range(0, 1));
      end
      default: r.value = $urandom;
    endcase
    return r;
  endfunction

  function automatic int idle_pct(input int sent, input int total);
    case (sent * 4 / total)
      1: return 53;
      3: return 30;
      default: return 0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        queue_conversion(req);
        sent_count++;
      end
      if (!(start && busy)) begin
        if (pending_reqs.size() > 0 &&
            $urandom_range(0, 99) >= idle_pct(sent_count, total_items)) begin
          req <= pending_reqs.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected beat: character %h last %b", res.character, res.last);
        error_count++;
      end else begin
        want = expected_chars.pop_front();
        if (res.character !== want.character) begin
          $error("character: expected %h, got %h", want.character, res.character);
          error_count++;
        end
        if (res.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, res.last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[int_to_text_formatter_core] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    pending_reqs.push_back(make_req(32'd0, 0, RADIX_DEC, SIGN_NONE, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(32'd0, 0, RADIX_DEC, SIGN_NONE, 0, 0, 0, 0, 0, 1, 0));
    pending_reqs.push_back(make_req(32'd0, 0, RADIX_HEX, SIGN_NONE, 0, 0, 0, 1, 5, 1, 0));
    pending_reqs.push_back(make_req(32'd0, 1, RADIX_DEC, SIGN_FORCE, 0, 1, 0, 1, 4, 1, 0));
    pending_reqs.push_back(make_req(32'd0, 0, RADIX_OCT, SIGN_NONE, 1, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(32'd0, 0, RADIX_HEX, SIGN_NONE, 1, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(32'd0, 0, RADIX_HEX, SIGN_NONE, 1, 0, 0, 0, 0, 1, 0));
    pending_reqs.push_back(make_req('1, 0, RADIX_DEC, SIGN_NONE, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req('1, 1, RADIX_DEC, SIGN_FORCE, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(32'h8000_0000, 1, RADIX_DEC, SIGN_NONE, 0, 0, 1, 1, 15,
                                    0, 0));
    pending_reqs.push_back(make_req(32'h7fff_ffff, 1, RADIX_DEC, SIGN_FORCE, 0, 0, 0, 0, 0,
                                    0, 0));
    pending_reqs.push_back(make_req(32'd42, 1, RADIX_DEC, SIGN_BLANK, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(32'd42, 1, RADIX_DEC, SIGN_RSVD, 0, 0, 0, 1, 6, 0, 0));
    pending_reqs.push_back(make_req(32'd42, 0, RADIX_RSVD, SIGN_FORCE, 1, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req('1, 0, RADIX_OCT, SIGN_NONE, 1, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req('1, 0, RADIX_HEX, SIGN_NONE, 1, 1, 0, 1, 60, 0, 0));
    pending_reqs.push_back(make_req(32'h1234, 1, RADIX_HEX, SIGN_FORCE, 1, 0, 1, 1, 63, 0, 0));
    pending_reqs.push_back(make_req(32'hdead, 1, RADIX_HEX, SIGN_FORCE, 1, 0, 0, 1, 63, 1,
                                    63));
    pending_reqs.push_back(make_req(32'd7, 0, RADIX_OCT, SIGN_NONE, 1, 0, 0, 0, 0, 1, 60));
    pending_reqs.push_back(make_req(-32'sd5, 1, RADIX_DEC, SIGN_NONE, 0, 0, 1, 1, 10, 1, 3));
    pending_reqs.push_back(make_req(-32'sd5, 1, RADIX_DEC, SIGN_NONE, 0, 1, 1, 1, 10, 0, 0));
    pending_reqs.push_back(make_req(32'd99, 0, RADIX_DEC, SIGN_NONE, 0, 0, 1, 0, 40, 0, 40));
    pending_reqs.push_back(make_req(32'hff, 0, RADIX_HEX, SIGN_NONE, 0, 0, 1, 1, 8, 0, 0));
    pending_reqs.push_back(make_req(32'o777, 0, RADIX_OCT, SIGN_NONE, 1, 0, 1, 1, 8, 0, 0));
    repeat (RANDOM_ITEMS) pending_reqs.push_back(random_req());
    total_items = pending_reqs.size();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    while (pending_reqs.size() != 0 || start || expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_chars.size() == 0) begin
      $display("[int_to_text_formatter_core] OK");
    end else begin
      $display("[int_to_text_formatter_core] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/itf_pkg.sv
rtl/itf_digits.sv
rtl/int_to_text_formatter_core.sv
rtl/itf_checker.sv
verif/testbench.sv
